/* rtl/qpsa_pkg.sv */
// ----------------------------------------------------------------------------
// qpsa_pkg
// Shared constants and types of the quaternion product square accumulator.
// ----------------------------------------------------------------------------
package qpsa_pkg;

   // Width of the accumulators and of the result components.
   localparam int ACC_WIDTH   = 64;

   // Depth of the queue between the product pipeline and the accumulator.
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   // Number of register stages in the product pipeline.
   localparam int FRONT_STAGES = 4;

   // Queue state as seen by the accumulator side.
   typedef struct packed {
      logic not_empty;
      logic full;
      logic head_last;
   } queue_status_type;

endpackage

/* rtl/quaternion_product_square_accumulate.sv */
// ----------------------------------------------------------------------------
// quaternion_product_square_accumulate
// Accumulates the squared Hamilton product of quaternion pairs.
// ----------------------------------------------------------------------------
// Each request word carries two quaternions a and b and a last flag. The
// block forms c = a * b, then s = c * c, and adds the four components of s
// into four saturating 64-bit accumulators that start at zero. A word with
// the last flag set is added first; then the four sums go out as one
// response word and the accumulators clear. Words without the flag give
// no response.
// Both channels use valid and stall; a word moves on a rising edge where
// valid is high and stall is low. Words can stream at one per cycle
// while req_stall stays low. The first word after a flagged word may
// follow at once. From request to response a word passes the four pipeline
// registers in the product path, an entry of the queue and the result
// register behind the accumulator.
// An eight-word queue sits between the product pipeline and the
// accumulator. While the receiver stalls, the accumulator keeps taking
// unflagged words; a flagged word waits at the queue head, and once the
// queue and the pipeline hold eight words, req_stall rises.
// Reset clears the accumulators, the queue and all valid flags.
// ----------------------------------------------------------------------------
module quaternion_product_square_accumulate
   import qpsa_pkg::*;
#(
   parameter int COMP_WIDTH = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COMP_WIDTH-1:0]  req_a_real,
   input  logic signed [COMP_WIDTH-1:0]  req_a_i,
   input  logic signed [COMP_WIDTH-1:0]  req_a_j,
   input  logic signed [COMP_WIDTH-1:0]  req_a_k,
   input  logic signed [COMP_WIDTH-1:0]  req_b_real,
   input  logic signed [COMP_WIDTH-1:0]  req_b_i,
   input  logic signed [COMP_WIDTH-1:0]  req_b_j,
   input  logic signed [COMP_WIDTH-1:0]  req_b_k,
   input  logic                          req_last_pair,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ACC_WIDTH-1:0]   rsp_sum_real,
   output logic signed [ACC_WIDTH-1:0]   rsp_sum_i,
   output logic signed [ACC_WIDTH-1:0]   rsp_sum_j,
   output logic signed [ACC_WIDTH-1:0]   rsp_sum_k
);

   localparam int SW = 4 * COMP_WIDTH + 6;

   logic signed [COMP_WIDTH-1:0] in_a [4];
   logic signed [COMP_WIDTH-1:0] in_b [4];
   logic                         push;
   logic                         push_last;
   logic signed [SW-1:0]         push_s [4];
   logic signed [SW-1:0]         head_s [4];
   logic                         pop;
   queue_status_type             status;
   logic signed [ACC_WIDTH-1:0]  out_sum [4];

   assign in_a[0] = req_a_real;
   assign in_a[1] = req_a_i;
   assign in_a[2] = req_a_j;
   assign in_a[3] = req_a_k;
   assign in_b[0] = req_b_real;
   assign in_b[1] = req_b_i;
   assign in_b[2] = req_b_j;
   assign in_b[3] = req_b_k;

   // Product pipeline with credit-based admission.
   qpsa_front #(.COMP_WIDTH(COMP_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_a      (in_a),
      .in_b      (in_b),
      .in_last   (req_last_pair),
      .pop       (pop),
      .push      (push),
      .push_last (push_last),
      .push_s    (push_s)
   );

   // Decoupling queue of squared products.
   qpsa_queue #(.COMP_WIDTH(COMP_WIDTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_last (push_last),
      .push_s    (push_s),
      .pop       (pop),
      .head_s    (head_s),
      .status    (status)
   );

   // Saturating accumulators and the response register.
   qpsa_back #(.COMP_WIDTH(COMP_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .head_s    (head_s),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_sum   (out_sum)
   );

   assign rsp_sum_real = out_sum[0];
   assign rsp_sum_i    = out_sum[1];
   assign rsp_sum_j    = out_sum[2];
   assign rsp_sum_k    = out_sum[3];

`ifndef NO_ASSERTIONS
   // The credit scheme must keep the pipeline from writing into a full queue.
   assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("product pipeline wrote into a full queue");

   // The accumulator only reads words that are present.
   assert property (@(posedge clock) disable iff (reset) pop |-> status.not_empty)
      else $error("accumulator read an empty queue");

   // Taking a flagged word always produces a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      pop && status.head_last |=> rsp_valid)
      else $error("flagged word taken without a response");
`endif

endmodule

/* rtl/qpsa_front.sv */
// ----------------------------------------------------------------------------
// qpsa_front
// Input side: accepts words, forms the Hamilton product and its square.
// ----------------------------------------------------------------------------
module qpsa_front
   import qpsa_pkg::*;
#(
   parameter int COMP_WIDTH = 11
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_stall,
   input  logic signed [COMP_WIDTH-1:0]           in_a [4],
   input  logic signed [COMP_WIDTH-1:0]           in_b [4],
   input  logic                                   in_last,
   input  logic                                   pop,
   output logic                                   push,
   output logic                                   push_last,
   output logic signed [4*COMP_WIDTH+5:0]         push_s [4]
);

   localparam int PW = 2 * COMP_WIDTH;
   localparam int CW = PW + 2;
   localparam int QW = 2 * CW;
   localparam int SW = QW + 2;

   logic [CNT_WIDTH-1:0]    credit_ff, credit_in;
   logic                    accept;
   logic [FRONT_STAGES-1:0] valid_ff, valid_in;
   logic [FRONT_STAGES-1:0] last_ff, last_in;

   logic signed [COMP_WIDTH-1:0] a_ff [4];
   logic signed [COMP_WIDTH-1:0] b_ff [4];
   logic signed [PW-1:0]         prod_ff [16];
   logic signed [PW-1:0]         prod_in [16];
   logic signed [CW-1:0]         c_ff [4];
   logic signed [CW-1:0]         c_in [4];
   logic signed [QW-1:0]         sq_ff [16];
   logic signed [QW-1:0]         sq_in [16];

   // Credits cover every word in the pipeline or the queue, so the
   // pipeline never has to hold: a word leaving it always finds room.
   assign in_stall = (credit_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign accept   = in_valid && !in_stall;

   always_comb begin
      credit_in = credit_ff + CNT_WIDTH'(accept) - CNT_WIDTH'(pop);
      valid_in  = {valid_ff[FRONT_STAGES-2:0], accept};
      last_in   = {last_ff[FRONT_STAGES-2:0], in_last};
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_in[4*i+j] = a_ff[i] * b_ff[j];
            sq_in[4*i+j]   = c_ff[i] * c_ff[j];
         end
      end
   end

   // Hamilton product c = a * b from the registered partial products.
   always_comb begin
      c_in[0] = CW'(prod_ff[0])  - CW'(prod_ff[5])  - CW'(prod_ff[10]) - CW'(prod_ff[15]);
      c_in[1] = CW'(prod_ff[1])  + CW'(prod_ff[4])  + CW'(prod_ff[11]) - CW'(prod_ff[14]);
      c_in[2] = CW'(prod_ff[2])  - CW'(prod_ff[7])  + CW'(prod_ff[8])  + CW'(prod_ff[13]);
      c_in[3] = CW'(prod_ff[3])  + CW'(prod_ff[6])  - CW'(prod_ff[9])  + CW'(prod_ff[12]);
   end

   // Square s = c * c, written straight into the queue.
   assign push_s[0] = SW'(sq_ff[0]) - SW'(sq_ff[5]) - SW'(sq_ff[10]) - SW'(sq_ff[15]);
   assign push_s[1] = SW'(sq_ff[1]) + SW'(sq_ff[4]) + SW'(sq_ff[11]) - SW'(sq_ff[14]);
   assign push_s[2] = SW'(sq_ff[2]) - SW'(sq_ff[7]) + SW'(sq_ff[8])  + SW'(sq_ff[13]);
   assign push_s[3] = SW'(sq_ff[3]) + SW'(sq_ff[6]) - SW'(sq_ff[9])  + SW'(sq_ff[12]);

   assign push      = valid_ff[FRONT_STAGES-1];
   assign push_last = last_ff[FRONT_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         valid_ff  <= '0;
      end else begin
         credit_ff <= credit_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      a_ff    <= in_a;
      b_ff    <= in_b;
      prod_ff <= prod_in;
      c_ff    <= c_in;
      sq_ff   <= sq_in;
   end

endmodule

/* rtl/qpsa_queue.sv */
// ----------------------------------------------------------------------------
// qpsa_queue
// Short first-in first-out queue of squared products between the two sides.
// ----------------------------------------------------------------------------
module qpsa_queue
   import qpsa_pkg::*;
#(
   parameter int COMP_WIDTH = 11
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           push_last,
   input  logic signed [4*COMP_WIDTH+5:0] push_s [4],
   input  logic                           pop,
   output logic signed [4*COMP_WIDTH+5:0] head_s [4],
   output queue_status_type               status
);

   localparam int SW      = 4 * COMP_WIDTH + 6;
   localparam int ENTRY_W = 4 * SW + 1;

   logic [ENTRY_W-1:0]    entry_ff [QUEUE_DEPTH];
   logic [ENTRY_W-1:0]    head;
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_WIDTH'(push) - CNT_WIDTH'(pop);
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign head_s[0] = head[SW-1:0];
   assign head_s[1] = head[2*SW-1:SW];
   assign head_s[2] = head[3*SW-1:2*SW];
   assign head_s[3] = head[4*SW-1:3*SW];

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign status.head_last = head[ENTRY_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= {push_last, push_s[3], push_s[2], push_s[1], push_s[0]};
      end
   end

endmodule

/* rtl/qpsa_back.sv */
// ----------------------------------------------------------------------------
// qpsa_back
// Accumulator side: saturating 64-bit sums and the result register.
// ----------------------------------------------------------------------------
module qpsa_back
   import qpsa_pkg::*;
#(
   parameter int COMP_WIDTH = 11
) (
   input  logic                           clock,
   input  logic                           reset,
   input  queue_status_type               status,
   input  logic signed [4*COMP_WIDTH+5:0] head_s [4],
   output logic                           pop,
   output logic                           out_valid,
   input  logic                           out_stall,
   output logic signed [ACC_WIDTH-1:0]    out_sum [4]
);

   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   logic signed [ACC_WIDTH-1:0] acc_ff [4];
   logic signed [ACC_WIDTH-1:0] acc_in [4];
   logic signed [ACC_WIDTH-1:0] next_acc [4];
   logic signed [ACC_WIDTH-1:0] addend [4];
   logic signed [ACC_WIDTH:0]   wide [4];
   logic signed [ACC_WIDTH-1:0] sum_ff [4];
   logic signed [ACC_WIDTH-1:0] sum_in [4];
   logic                        valid_ff, valid_in;
   logic                        take_last;

   // A word without the last flag never touches the result register.
   assign pop       = status.not_empty && (!status.head_last || !valid_ff || !out_stall);
   assign take_last = pop && status.head_last;

   always_comb begin
      for (int n = 0; n < 4; n++) begin
         addend[n]   = ACC_WIDTH'(head_s[n]);
         wide[n]     = (ACC_WIDTH+1)'(acc_ff[n]) + (ACC_WIDTH+1)'(addend[n]);
         if (wide[n][ACC_WIDTH] != wide[n][ACC_WIDTH-1]) begin
            next_acc[n] = wide[n][ACC_WIDTH] ? ACC_MIN : ACC_MAX;
         end else begin
            next_acc[n] = wide[n][ACC_WIDTH-1:0];
         end
         if (take_last) begin
            acc_in[n] = '0;
            sum_in[n] = next_acc[n];
         end else if (pop) begin
            acc_in[n] = next_acc[n];
            sum_in[n] = sum_ff[n];
         end else begin
            acc_in[n] = acc_ff[n];
            sum_in[n] = sum_ff[n];
         end
      end
      if (take_last) begin
         valid_in = 1'b1;
      end else if (valid_ff && !out_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   assign out_valid = valid_ff;
   assign out_sum   = sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int n = 0; n < 4; n++) begin
            acc_ff[n] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

endmodule

/* test/quaternion_product_square_accumulate_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_product_square_accumulate_tb
// Self-checking bench for the quaternion product square accumulator.
// ----------------------------------------------------------------------------
// Request words are driven on the falling clock edge and both channels are
// sampled on the rising edge. A small scoreboard class keeps its own four
// saturating accumulators. For every accepted request word it forms the
// squared Hamilton product and, on a flagged word, queues the expected sums.
// Every accepted response word is checked against the oldest expected sums.
// The run covers directed corner words, two long vectors of near-maximal
// products that push the real sum far up and far down, random vectors under
// several idle and stall mixes, and a long receiver hold-off that backs up
// the block's internal queue.
// ----------------------------------------------------------------------------
module quaternion_product_square_accumulate_tb;
   import qpsa_pkg::*;

   localparam int COMP_W = 11;
   localparam int HOLD_CYCLES = 400;
   // Words in each long vector of near-maximal products.
   localparam int LONG_WORDS = 50;

   typedef logic signed [COMP_W-1:0] comp_type;

   localparam comp_type COMP_MAX = comp_type'((1 << (COMP_W - 1)) - 1);
   localparam comp_type COMP_MIN = comp_type'(1 << (COMP_W - 1));

   // One request word: both quaternions and the last flag.
   typedef struct packed {
      comp_type a_real;
      comp_type a_i;
      comp_type a_j;
      comp_type a_k;
      comp_type b_real;
      comp_type b_i;
      comp_type b_j;
      comp_type b_k;
      logic     last;
   } pair_word_type;

   typedef struct {
      longint w;
      longint x;
      longint y;
      longint z;
   } quat_type;

   // One response word: the four accumulated components.
   typedef struct {
      logic signed [ACC_WIDTH-1:0] r;
      logic signed [ACC_WIDTH-1:0] i;
      logic signed [ACC_WIDTH-1:0] j;
      logic signed [ACC_WIDTH-1:0] k;
   } sum_set_type;

   // Running sums of the squared products and the sums still owed by the
   // block, oldest first.
   class quat_sum_scoreboard_type;
      sum_set_type running;
      sum_set_type expected_sums[$];
      int          mismatches;

      function new();
         running.r = '0;
         running.i = '0;
         running.j = '0;
         running.k = '0;
         mismatches = 0;
      endfunction

      static function quat_type hamilton(quat_type p, quat_type q);
         quat_type o;
         o.w = p.w * q.w - p.x * q.x - p.y * q.y - p.z * q.z;
         o.x = p.w * q.x + p.x * q.w + p.y * q.z - p.z * q.y;
         o.y = p.w * q.y - p.x * q.z + p.y * q.w + p.z * q.x;
         o.z = p.w * q.z + p.x * q.y - p.y * q.x + p.z * q.w;
         return o;
      endfunction

      static function logic signed [ACC_WIDTH-1:0] clamp_add(
            logic signed [ACC_WIDTH-1:0] acc, longint term);
         logic signed [ACC_WIDTH:0] wide;
         wide = acc + term;
         if (wide[ACC_WIDTH] != wide[ACC_WIDTH-1])
            return wide[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                   : {1'b0, {(ACC_WIDTH-1){1'b1}}};
         return wide[ACC_WIDTH-1:0];
      endfunction

      function void add_pair(pair_word_type word);
         quat_type qa;
         quat_type qb;
         quat_type c;
         quat_type s;
         qa.w = longint'($signed(word.a_real));
         qa.x = longint'($signed(word.a_i));
         qa.y = longint'($signed(word.a_j));
         qa.z = longint'($signed(word.a_k));
         qb.w = longint'($signed(word.b_real));
         qb.x = longint'($signed(word.b_i));
         qb.y = longint'($signed(word.b_j));
         qb.z = longint'($signed(word.b_k));
         c = hamilton(qa, qb);
         s = hamilton(c, c);
         running.r = clamp_add(running.r, s.w);
         running.i = clamp_add(running.i, s.x);
         running.j = clamp_add(running.j, s.y);
         running.k = clamp_add(running.k, s.z);
         if (word.last) begin
            expected_sums.push_back(running);
            running.r = '0;
            running.i = '0;
            running.j = '0;
            running.k = '0;
         end
      endfunction

      function void check_sums(sum_set_type got);
         sum_set_type want;
         if (expected_sums.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected response word: %0d %0d %0d %0d",
                        got.r, got.i, got.j, got.k);
            mismatches++;
         end else begin
            want = expected_sums.pop_front();
            if (got.r !== want.r || got.i !== want.i ||
                got.j !== want.j || got.k !== want.k) begin
               if (mismatches < 10)
                  $display("sum mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                           want.r, want.i, want.j, want.k,
                           got.r, got.i, got.j, got.k);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_sums.size();
      endfunction
   endclass

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   comp_type req_a_real = '0;
   comp_type req_a_i = '0;
   comp_type req_a_j = '0;
   comp_type req_a_k = '0;
   comp_type req_b_real = '0;
   comp_type req_b_i = '0;
   comp_type req_b_j = '0;
   comp_type req_b_k = '0;
   logic     req_last_pair = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   logic signed [ACC_WIDTH-1:0] rsp_sum_real;
   logic signed [ACC_WIDTH-1:0] rsp_sum_i;
   logic signed [ACC_WIDTH-1:0] rsp_sum_j;
   logic signed [ACC_WIDTH-1:0] rsp_sum_k;

   // Percentages of cycles in which the sender idles and the receiver
   // stalls. The main sequence changes them between phases.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // The main sequence bumps hold_asked to ask the receiver for one long
   // hold-off; the receiver counts hold_given as it serves each one.
   int hold_asked = 0;
   int hold_given = 0;

   quat_sum_scoreboard_type sums;

   quaternion_product_square_accumulate uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_a_real    (req_a_real),
      .req_a_i       (req_a_i),
      .req_a_j       (req_a_j),
      .req_a_k       (req_a_k),
      .req_b_real    (req_b_real),
      .req_b_i       (req_b_i),
      .req_b_j       (req_b_j),
      .req_b_k       (req_b_k),
      .req_last_pair (req_last_pair),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sum_real  (rsp_sum_real),
      .rsp_sum_i     (rsp_sum_i),
      .rsp_sum_j     (rsp_sum_j),
      .rsp_sum_k     (rsp_sum_k)
   );

   always #4 clock = ~clock;

   function automatic pair_word_type make_word(int ar, int ai, int aj, int ak,
                                               int br, int bi, int bj, int bk,
                                               bit last);
      pair_word_type word;
      word.a_real = comp_type'(ar);
      word.a_i    = comp_type'(ai);
      word.a_j    = comp_type'(aj);
      word.a_k    = comp_type'(ak);
      word.b_real = comp_type'(br);
      word.b_i    = comp_type'(bi);
      word.b_j    = comp_type'(bj);
      word.b_k    = comp_type'(bk);
      word.last   = last;
      return word;
   endfunction

   // Components lean toward the range ends and zero, where the product
   // terms are largest or vanish; the rest are uniform over all bits.
   function automatic comp_type random_comp();
      case ($urandom_range(7, 0))
         0: return COMP_MIN;
         1: return COMP_MAX;
         2: return '0;
         default: return comp_type'($urandom);
      endcase
   endfunction

   function automatic pair_word_type random_word(bit last);
      pair_word_type word;
      word.a_real = random_comp();
      word.a_i    = random_comp();
      word.a_j    = random_comp();
      word.a_k    = random_comp();
      word.b_real = random_comp();
      word.b_i    = random_comp();
      word.b_j    = random_comp();
      word.b_k    = random_comp();
      word.last   = last;
      return word;
   endfunction

   task automatic drive_payload(pair_word_type word);
      req_a_real    = word.a_real;
      req_a_i       = word.a_i;
      req_a_j       = word.a_j;
      req_a_k       = word.a_k;
      req_b_real    = word.b_real;
      req_b_i       = word.b_i;
      req_b_j       = word.b_j;
      req_b_k       = word.b_k;
      req_last_pair = word.last;
   endtask

   // Entered and left on a falling edge. Idle cycles come first, with
   // junk on the payload, then the word is held until the block takes it.
   task automatic send_word(pair_word_type word);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid = 1'b0;
         drive_payload(random_word($urandom_range(1, 0)));
         @(negedge clock);
      end
      req_valid = 1'b1;
      drive_payload(word);
      do
         @(posedge clock);
      while (req_stall);
      sums.add_pair(word);
      @(negedge clock);
   endtask

   task automatic wait_for_sums();
      req_valid = 1'b0;
      while (sums.pending() != 0)
         @(negedge clock);
   endtask

   // One long vector of the same word, flagged at its end.
   task automatic send_repeated(pair_word_type word, int count);
      for (int n = 0; n < count; n++) begin
         word.last = (n == count - 1);
         send_word(word);
      end
   endtask

   // Random vectors, mostly short, some long. Now and then the sender
   // waits until every owed response word has come back.
   task automatic send_random_vectors(int count);
      int len;
      int sent;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 1)
                                           : $urandom_range(4, 1);
         for (int n = 0; n < len; n++)
            send_word(random_word(n == len - 1));
         sent += len;
         if ($urandom_range(39, 0) == 0)
            wait_for_sums();
      end
   endtask

   // Receiver: a fresh stall decision every cycle, except while serving a
   // hold-off, when stall stays high throughout; HOLD_CYCLES sets its length.
   initial begin
      int held;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_given) begin
            hold_given = hold_given + 1;
            for (held = 0; held < HOLD_CYCLES; held++) begin
               rsp_stall = 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall = (recv_stall_pct != 0) &&
                     ($urandom_range(99, 0) < recv_stall_pct);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      sum_set_type got;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         got.r = rsp_sum_real;
         got.i = rsp_sum_i;
         got.j = rsp_sum_j;
         got.k = rsp_sum_k;
         sums.check_sums(got);
      end
   end

   initial begin
      sums = new();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words: range ends, unit quaternions, bit patterns and
      // back-to-back flagged words, all at full rate.
      send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
      send_word(make_word(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1'b1));
      send_word(make_word(-1024, -1024, -1024, -1024,
                          -1024, -1024, -1024, -1024, 1'b1));
      send_word(make_word(-1024, -1024, -1024, -1024, 1023, 1023, 1023, 1023, 1'b0));
      send_word(make_word(1023, 1023, 1023, 1023, -1024, -1024, -1024, -1024, 1'b1));
      send_word(make_word(1, 0, 0, 0, 1, 0, 0, 0, 1'b1));
      send_word(make_word(0, 1, 0, 0, 0, 0, 1, 0, 1'b1));
      send_word(make_word(0, 0, 1, 0, 0, 1, 0, 0, 1'b1));
      send_word(make_word(0, 0, 0, 1, 0, 0, 0, 1, 1'b0));
      send_word(make_word(-1, -1, -1, -1, -1, -1, -1, -1, 1'b1));
      send_word(make_word(-683, 682, -683, 682, 682, -683, 682, -683, 1'b1));
      send_word(make_word(682, -683, 682, -683, -683, 682, -683, 682, 1'b0));
      send_word(make_word(1023, -1024, 1023, -1024, 1023, 1024, -1023, 1024, 1'b0));
      send_word(make_word(-1024, 1023, 0, 0, 0, 0, 1023, -1024, 1'b1));
      send_word(make_word(7, -3, 250, -511, 512, 99, -1, 1, 1'b1));
      send_word(make_word(1023, 0, 0, 0, 0, 0, 0, -1024, 1'b0));
      send_word(make_word(0, -1024, 0, 0, 0, 0, 1023, 0, 1'b1));
      wait_for_sums();

      // A real product squared adds about 2^44 per word to the real sum.
      send_repeated(make_word(-1024, 1023, 1023, 1023,
                              -1024, -1023, -1023, -1023, 1'b0), LONG_WORDS);
      // A pure vector product squared subtracts about 2^44 per word.
      send_repeated(make_word(-1024, -1024, -1024, -1024,
                              -1024, -1024, -1023, 1023, 1'b0), LONG_WORDS);
      wait_for_sums();

      // Random vectors under four idle and stall mixes.
      send_random_vectors(450);
      send_idle_pct = 83;
      recv_stall_pct = 0;
      wait_for_sums();
      send_random_vectors(450);
      send_idle_pct = 0;
      recv_stall_pct = 83;
      send_random_vectors(450);
      send_idle_pct = 8;
      recv_stall_pct = 8;
      send_random_vectors(450);

      // Back-pressure: the receiver holds off while the sender streams
      // words, every second one flagged, so the queue fills and req_stall must rise.
      wait_for_sums();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_asked = hold_asked + 1;
      for (int n = 0; n < 64; n++)
         send_word(random_word(n[0]));

      wait_for_sums();
      repeat (20) @(negedge clock);

      if (sums.mismatches == 0 && sums.pending() == 0)
         $display("quaternion_product_square_accumulate test passed");
      else
         $display("quaternion_product_square_accumulate test failed");
      $finish;
   end

   // Many times the slowest expected run.
   initial begin
      #2_000_000;
      $display("quaternion_product_square_accumulate test failed");
      $finish;
   end

endmodule
